>>> hdl/tpd_pkg.sv
// Package for the touch presence detector: widths, reset values, register
// codes and the item record passed from the input stage to the core.
// No dependencies.
package tpd_pkg;

    localparam int SAMPLE_W  = 22;   // raw reading and baseline width
    localparam int CNT_W     = 4;    // streak/calibration counters and remainders
    localparam int REM_SUM_W = CNT_W + 1;
    localparam int RATIO_W   = 16;   // unsigned Q0.16
    localparam int CFG_IDX_W = 1;

    localparam int CAL_SAMPLES_DEF = 10;
    localparam int LOW_STREAK_DEF  = 10;
    localparam int RAW_BITS_DEF    = 22;

    localparam logic [RATIO_W-1:0] ACTIVE_RATIO_RST = 16'd13107;  // 0.20
    localparam logic [RATIO_W-1:0] HYSTERESIS_RST   = 16'd3277;   // 0.05

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_RATIO = 1'b0,
        REG_HYSTERESIS   = 1'b1
    } cfg_reg_t;

    // Sample pre-split into quotient and remainder by both averaging lengths
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic                ok;
        logic [SAMPLE_W-1:0] cal_q;
        logic [CNT_W-1:0]    cal_r;
        logic [SAMPLE_W-1:0] ls_q;
        logic [CNT_W-1:0]    ls_r;
    } tpd_item_t;

endpackage

>>> hdl/tpd_in_stage.sv
// Input register of the touch presence detector: masks the reading and
// splits it by the calibration and low-streak lengths. Uses tpd_pkg.
module tpd_in_stage #(
    parameter int CAL_SAMPLES = tpd_pkg::CAL_SAMPLES_DEF,
    parameter int LOW_STREAK  = tpd_pkg::LOW_STREAK_DEF,
    parameter int RAW_BITS    = tpd_pkg::RAW_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [tpd_pkg::SAMPLE_W-1:0]  raw_sample,
    input  logic                          read_ok,
    output logic                          item_valid,
    output tpd_pkg::tpd_item_t            item,
    input  logic                          item_take
);

    localparam int MaskW = (RAW_BITS < tpd_pkg::SAMPLE_W) ? RAW_BITS : tpd_pkg::SAMPLE_W;
    localparam logic [tpd_pkg::SAMPLE_W-1:0] RawMask =
        tpd_pkg::SAMPLE_W'((64'd1 << MaskW) - 64'd1);
    localparam logic [tpd_pkg::SAMPLE_W-1:0] CalDiv = tpd_pkg::SAMPLE_W'(CAL_SAMPLES);
    localparam logic [tpd_pkg::SAMPLE_W-1:0] LsDiv  = tpd_pkg::SAMPLE_W'(LOW_STREAK);

    // Reciprocals rounded up: the shifted product is the exact floor quotient
    // for every reading that fits the sample width
    localparam int CalSh  = tpd_pkg::SAMPLE_W + $clog2(CAL_SAMPLES);
    localparam int LsSh   = tpd_pkg::SAMPLE_W + $clog2(LOW_STREAK);
    localparam int RecipW = tpd_pkg::SAMPLE_W + 1;
    localparam int ProdW  = tpd_pkg::SAMPLE_W + RecipW;
    localparam logic [RecipW-1:0] CalRecip =
        RecipW'(((64'd1 << CalSh) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [RecipW-1:0] LsRecip =
        RecipW'(((64'd1 << LsSh) + 64'(LOW_STREAK) - 64'd1) / 64'(LOW_STREAK));

    logic                          vld_reg;
    logic                          vld_next;
    tpd_pkg::tpd_item_t            item_reg;
    tpd_pkg::tpd_item_t            item_next;
    logic [tpd_pkg::SAMPLE_W-1:0]  raw_m;
    logic                          accept;
    logic [ProdW-1:0]              cal_prod;
    logic [ProdW-1:0]              ls_prod;
    logic [tpd_pkg::SAMPLE_W-1:0]  cal_quo;
    logic [tpd_pkg::SAMPLE_W-1:0]  ls_quo;
    logic [tpd_pkg::SAMPLE_W-1:0]  cal_rem;
    logic [tpd_pkg::SAMPLE_W-1:0]  ls_rem;

    assign sample_ready = !vld_reg || item_take;
    assign accept       = sample_valid && sample_ready;
    assign raw_m        = raw_sample & RawMask;

    assign cal_prod = ProdW'(raw_m) * ProdW'(CalRecip);
    assign cal_quo  = tpd_pkg::SAMPLE_W'(cal_prod >> CalSh);
    assign cal_rem  = raw_m - cal_quo * CalDiv;
    assign ls_prod  = ProdW'(raw_m) * ProdW'(LsRecip);
    assign ls_quo   = tpd_pkg::SAMPLE_W'(ls_prod >> LsSh);
    assign ls_rem   = raw_m - ls_quo * LsDiv;

    always_comb
    begin
        item_next       = item_reg;
        vld_next        = vld_reg;
        if (accept)
        begin
            item_next.raw   = raw_m;
            item_next.ok    = read_ok;
            item_next.cal_q = cal_quo;
            item_next.cal_r = tpd_pkg::CNT_W'(cal_rem);
            item_next.ls_q  = ls_quo;
            item_next.ls_r  = tpd_pkg::CNT_W'(ls_rem);
            vld_next        = 1'b1;
        end
        else if (item_take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

>>> hdl/tpd_core.sv
// Detector core: calibration, baseline drift tracking, hysteresis threshold,
// debounce, configuration registers and the result register. Uses tpd_pkg.
module tpd_core #(
    parameter int CAL_SAMPLES = tpd_pkg::CAL_SAMPLES_DEF,
    parameter int LOW_STREAK  = tpd_pkg::LOW_STREAK_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  tpd_pkg::tpd_item_t             item,
    output logic                           item_take,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpd_pkg::RATIO_W-1:0]    cfg_data,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           present,
    output logic                           touch_active,
    output logic                           calibrated,
    output logic [tpd_pkg::SAMPLE_W-1:0]   baseline_out
);

    localparam int SW = tpd_pkg::SAMPLE_W;
    localparam int CW = tpd_pkg::CNT_W;
    localparam int RW = tpd_pkg::RATIO_W;
    localparam int PW = SW + RW;

    logic [RW-1:0] ratio_reg, ratio_next;
    logic [RW-1:0] hyst_reg, hyst_next;

    logic [SW-1:0] baseline_reg, baseline_next;
    logic          cal_done_reg, cal_done_next;
    logic [CW-1:0] cal_cnt_reg, cal_cnt_next;
    logic [SW-1:0] cal_q_reg, cal_q_next;
    logic [CW-1:0] cal_r_reg, cal_r_next;
    logic [CW-1:0] ls_cnt_reg, ls_cnt_next;
    logic [SW-1:0] ls_q_reg, ls_q_next;
    logic [CW-1:0] ls_r_reg, ls_r_next;
    logic          active_reg, active_next;
    logic          prev_reg, prev_next;
    logic          present_reg, present_next;

    logic          res_vld_reg, res_vld_next;
    logic          res_present_reg, res_present_next;
    logic          res_active_reg, res_active_next;
    logic          res_cal_reg, res_cal_next;
    logic [SW-1:0] res_base_reg, res_base_next;

    // Running averages kept as quotient and remainder by the averaging length
    logic [CW-1:0]              cal_cnt_inc;
    logic [tpd_pkg::REM_SUM_W-1:0] cal_rsum;
    logic                       cal_carry;
    logic [CW-1:0]              cal_rnew;
    logic [SW-1:0]              cal_qnew;
    logic [CW-1:0]              ls_cnt_inc;
    logic [tpd_pkg::REM_SUM_W-1:0] ls_rsum;
    logic                       ls_carry;
    logic [CW-1:0]              ls_rnew;
    logic [SW-1:0]              ls_qnew;
    logic                       is_low;
    logic                       ls_full;
    logic [SW-1:0]              base_upd;
    logic [RW-1:0]              ratio_sel;
    logic [PW-1:0]              prod;
    logic [SW-1:0]              delta;
    logic                       act_new;

    assign item_take = item_valid && (!res_vld_reg || result_ready);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cal_cnt_inc = cal_cnt_reg + CW'(1);
        cal_rsum    = {1'b0, cal_r_reg} + {1'b0, item.cal_r};
        cal_carry   = cal_rsum >= tpd_pkg::REM_SUM_W'(CAL_SAMPLES);
        cal_rnew    = cal_carry ? CW'(cal_rsum - tpd_pkg::REM_SUM_W'(CAL_SAMPLES))
                                : cal_rsum[CW-1:0];
        cal_qnew    = cal_q_reg + item.cal_q + SW'(cal_carry);

        ls_cnt_inc  = ls_cnt_reg + CW'(1);
        ls_rsum     = {1'b0, ls_r_reg} + {1'b0, item.ls_r};
        ls_carry    = ls_rsum >= tpd_pkg::REM_SUM_W'(LOW_STREAK);
        ls_rnew     = ls_carry ? CW'(ls_rsum - tpd_pkg::REM_SUM_W'(LOW_STREAK))
                               : ls_rsum[CW-1:0];
        ls_qnew     = ls_q_reg + item.ls_q + SW'(ls_carry);

        is_low      = (item.raw != '0) && (item.raw < baseline_reg);
        ls_full     = ls_cnt_inc >= CW'(LOW_STREAK);
        base_upd    = (item.ok && is_low && ls_full) ? ls_qnew : baseline_reg;

        // Lower the ratio by the hysteresis while touched, floor at zero
        if (active_reg)
        begin
            ratio_sel = (ratio_reg > hyst_reg) ? ratio_reg - hyst_reg : '0;
        end
        else
        begin
            ratio_sel = ratio_reg;
        end
        prod    = PW'(base_upd) * PW'(ratio_sel);
        delta   = (item.raw > base_upd) ? item.raw - base_upd : '0;
        act_new = delta > prod[PW-1:RW];
    end

    always_comb
    begin
        ratio_next       = ratio_reg;
        hyst_next        = hyst_reg;
        baseline_next    = baseline_reg;
        cal_done_next    = cal_done_reg;
        cal_cnt_next     = cal_cnt_reg;
        cal_q_next       = cal_q_reg;
        cal_r_next       = cal_r_reg;
        ls_cnt_next      = ls_cnt_reg;
        ls_q_next        = ls_q_reg;
        ls_r_next        = ls_r_reg;
        active_next      = active_reg;
        prev_next        = prev_reg;
        present_next     = present_reg;
        res_vld_next     = res_vld_reg;
        res_present_next = res_present_reg;
        res_active_next  = res_active_reg;
        res_cal_next     = res_cal_reg;
        res_base_next    = res_base_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (tpd_pkg::cfg_reg_t'(cfg_index))
                tpd_pkg::REG_ACTIVE_RATIO: ratio_next = cfg_data;
                tpd_pkg::REG_HYSTERESIS:   hyst_next  = cfg_data;
                default: ;
            endcase
        end

        if (result_valid && result_ready)
        begin
            res_vld_next = 1'b0;
        end

        if (item_take)
        begin
            if (!cal_done_reg)
            begin
                // Calibration: skip read errors, average the good readings
                if (item.ok)
                begin
                    if (cal_cnt_inc >= CW'(CAL_SAMPLES))
                    begin
                        baseline_next = cal_qnew;
                        cal_done_next = 1'b1;
                        cal_cnt_next  = '0;
                        cal_q_next    = '0;
                        cal_r_next    = '0;
                    end
                    else
                    begin
                        cal_cnt_next = cal_cnt_inc;
                        cal_q_next   = cal_qnew;
                        cal_r_next   = cal_rnew;
                    end
                end
                res_present_next = 1'b0;
                res_active_next  = 1'b0;
                res_cal_next     = cal_done_next;
                res_base_next    = baseline_next;
            end
            else
            begin
                ls_cnt_next = '0;
                ls_q_next   = '0;
                ls_r_next   = '0;
                if (item.ok)
                begin
                    if (is_low && !ls_full)
                    begin
                        ls_cnt_next = ls_cnt_inc;
                        ls_q_next   = ls_qnew;
                        ls_r_next   = ls_rnew;
                    end
                    baseline_next = base_upd;
                    active_next   = act_new;
                end
                // Two equal decisions in a row move presence
                if (active_next != prev_reg)
                begin
                    prev_next = active_next;
                end
                else if (active_next != present_reg)
                begin
                    present_next = active_next;
                end
                res_present_next = present_next;
                res_active_next  = active_next;
                res_cal_next     = 1'b1;
                res_base_next    = baseline_next;
            end
            res_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= tpd_pkg::ACTIVE_RATIO_RST;
            hyst_reg     <= tpd_pkg::HYSTERESIS_RST;
            baseline_reg <= '0;
            cal_done_reg <= 1'b0;
            cal_cnt_reg  <= '0;
            cal_q_reg    <= '0;
            cal_r_reg    <= '0;
            ls_cnt_reg   <= '0;
            ls_q_reg     <= '0;
            ls_r_reg     <= '0;
            active_reg   <= 1'b0;
            prev_reg     <= 1'b0;
            present_reg  <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            ratio_reg    <= ratio_next;
            hyst_reg     <= hyst_next;
            baseline_reg <= baseline_next;
            cal_done_reg <= cal_done_next;
            cal_cnt_reg  <= cal_cnt_next;
            cal_q_reg    <= cal_q_next;
            cal_r_reg    <= cal_r_next;
            ls_cnt_reg   <= ls_cnt_next;
            ls_q_reg     <= ls_q_next;
            ls_r_reg     <= ls_r_next;
            active_reg   <= active_next;
            prev_reg     <= prev_next;
            present_reg  <= present_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_present_reg <= res_present_next;
        res_active_reg  <= res_active_next;
        res_cal_reg     <= res_cal_next;
        res_base_reg    <= res_base_next;
    end

    assign result_valid = res_vld_reg;
    assign present      = res_present_reg;
    assign touch_active = res_active_reg;
    assign calibrated   = res_cal_reg;
    assign baseline_out = res_base_reg;

endmodule

>>> hdl/touch_presence_detector.sv
// Top level of the touch presence detector: input stage and core.
// Depends on tpd_pkg, tpd_in_stage and tpd_core.
//
// Usage:
//   Sample channel (sample_valid/sample_ready): one pad reading per poll with
//   its read-ok flag. Result channel (result_valid/result_ready): one result
//   item per sample with debounced presence, raw decision, calibration flag
//   and the current baseline. Config channel (cfg_valid/cfg_ready): index 0
//   writes the Q0.16 active ratio, index 1 the hysteresis; always ready; the
//   user must see they are written only while idle, the block does not check.
//   The sample passes the input register, then the result register; a
//   stalled result keeps the next item in the input register. Throughput:
//   one item per cycle while results are taken; baseline, streak and
//   debounce state update together in the core (one 22x16 multiply, compare).
//   Reset: valid flags and detector state clear, the ratio registers return to
//   0.20 and 0.05, and the first CAL_SAMPLES good readings form the baseline.
//   Stall: while result_ready is low the result holds; one more sample can
//   sit in the input register, after which sample_ready drops.
module touch_presence_detector #(
    parameter int CAL_SAMPLES = tpd_pkg::CAL_SAMPLES_DEF,
    parameter int LOW_STREAK  = tpd_pkg::LOW_STREAK_DEF,
    parameter int RAW_BITS    = tpd_pkg::RAW_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic [tpd_pkg::SAMPLE_W-1:0]   raw_sample,
    input  logic                           read_ok,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           present,
    output logic                           touch_active,
    output logic                           calibrated,
    output logic [tpd_pkg::SAMPLE_W-1:0]   baseline_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpd_pkg::RATIO_W-1:0]    cfg_data
);

    logic               item_valid;
    logic               item_take;
    tpd_pkg::tpd_item_t item;

    tpd_in_stage #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .LOW_STREAK  (LOW_STREAK),
        .RAW_BITS    (RAW_BITS)
    ) u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .raw_sample   (raw_sample),
        .read_ok      (read_ok),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    tpd_core #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .LOW_STREAK  (LOW_STREAK)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .present      (present),
        .touch_active (touch_active),
        .calibrated   (calibrated),
        .baseline_out (baseline_out)
    );

endmodule

>>> hdl/tpd_checker.sv
// Port-level checks for the touch presence detector, bound to the top level.
// Depends on tpd_pkg and touch_presence_detector.
module tpd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           sample_valid,
    input logic                           sample_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic                           present,
    input logic                           touch_active,
    input logic                           calibrated,
    input logic [tpd_pkg::SAMPLE_W-1:0]   baseline_out
);

    logic seen_cal_reg;
    logic last_present_reg;

    // Track calibration and presence over delivered items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_cal_reg     <= 1'b0;
            last_present_reg <= 1'b0;
        end
        else if (result_valid && result_ready)
        begin
            seen_cal_reg     <= seen_cal_reg || calibrated;
            last_present_reg <= present;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(present) && $stable(touch_active)
            && $stable(calibrated) && $stable(baseline_out))
        else $error("result changed while stalled");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("sample side blocked while results drain");

    a_calib_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !calibrated |-> !present && !touch_active)
        else $error("touch reported before calibration");

    a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !calibrated |-> !seen_cal_reg)
        else $error("calibration lost");

    a_present_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (present != last_present_reg) |-> touch_active == present)
        else $error("presence moved against the decision");

endmodule

bind touch_presence_detector tpd_checker u_tpd_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for touch_presence_detector: drives pad readings,
// predicts calibration, drift tracking, hysteresis and debounce per item.
// Depends on tpd_pkg and the touch_presence_detector RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int          SAMPLE_W        = tpd_pkg::SAMPLE_W;
    localparam int          RATIO_W         = tpd_pkg::RATIO_W;
    localparam int          CFG_IDX_W       = tpd_pkg::CFG_IDX_W;
    localparam int          CAL_SAMPLES_DEF = tpd_pkg::CAL_SAMPLES_DEF;
    localparam int          LOW_STREAK_DEF  = tpd_pkg::LOW_STREAK_DEF;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          STALL_CYCLES   = 60;
    localparam int          RANDOM_PHASES  = 7;
    localparam int          PHASE_ITEMS    = 90;
    localparam int          GAP_PERCENT    = 19;
    localparam int unsigned RAW_MAX        = (1 << SAMPLE_W) - 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic                ok;
    } pad_poll_t;

    typedef struct packed {
        logic                present;
        logic                active;
        logic                calibrated;
        logic [SAMPLE_W-1:0] baseline;
    } pad_result_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    logic [SAMPLE_W-1:0]   raw_sample   = '0;
    logic                  read_ok      = 1'b0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic                  present;
    logic                  touch_active;
    logic                  calibrated;
    logic [SAMPLE_W-1:0]   baseline_out;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = tpd_pkg::REG_ACTIVE_RATIO;
    logic [RATIO_W-1:0]    cfg_data     = '0;

    touch_presence_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .raw_sample   (raw_sample),
        .read_ok      (read_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .present      (present),
        .touch_active (touch_active),
        .calibrated   (calibrated),
        .baseline_out (baseline_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pad_poll_t   polls_waiting[$];
    pad_result_t results_due[$];

    int          n_queued      = 0;
    int          n_accepted    = 0;
    int          n_checked     = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          drift_updates = 0;
    int          presence_flips = 0;
    logic        hold_off      = 1'b0;
    bit          no_gaps       = 1'b0;
    int unsigned lvl;

    // Detector state as seen by the predictor
    logic [RATIO_W-1:0]  ratio_reg = tpd_pkg::ACTIVE_RATIO_RST;
    logic [RATIO_W-1:0]  hyst_reg  = tpd_pkg::HYSTERESIS_RST;
    logic [SAMPLE_W-1:0] base_est  = '0;
    int unsigned         cal_seen  = 0;
    longint unsigned     cal_acc   = 0;
    int unsigned         streak_len = 0;
    longint unsigned     streak_acc = 0;
    bit                  cal_done  = 1'b0;
    bit                  touch_now = 1'b0;
    bit                  last_decision = 1'b0;
    bit                  presence  = 1'b0;

    function automatic pad_result_t poll_pad(logic [SAMPLE_W-1:0] raw, logic ok);
        pad_result_t                 r;
        logic [SAMPLE_W-1:0]         rise;
        logic [RATIO_W-1:0]          frac;
        logic [SAMPLE_W+RATIO_W-1:0] prod;
        if (!cal_done)
        begin
            // read errors are skipped while the baseline is being formed
            if (ok)
            begin
                cal_acc += raw;
                cal_seen++;
                if (cal_seen >= CAL_SAMPLES_DEF)
                begin
                    base_est = SAMPLE_W'(cal_acc / CAL_SAMPLES_DEF);
                    cal_done = 1'b1;
                    cal_seen = 0;
                    cal_acc  = 0;
                end
            end
            r.present    = 1'b0;
            r.active     = 1'b0;
            r.calibrated = cal_done;
            r.baseline   = base_est;
            return r;
        end
        if (!ok)
        begin
            streak_len = 0;
            streak_acc = 0;
        end
        else
        begin
            if (raw != 0 && raw < base_est)
            begin
                streak_acc += raw;
                streak_len++;
                if (streak_len >= LOW_STREAK_DEF)
                begin
                    base_est   = SAMPLE_W'(streak_acc / LOW_STREAK_DEF);
                    streak_len = 0;
                    streak_acc = 0;
                    drift_updates++;
                end
            end
            else
            begin
                streak_len = 0;
                streak_acc = 0;
            end
            rise = (raw > base_est) ? raw - base_est : '0;
            frac = ratio_reg;
            if (touch_now)
                frac = (ratio_reg > hyst_reg) ? ratio_reg - hyst_reg : '0;
            prod = base_est * frac;
            touch_now = rise > prod[SAMPLE_W+RATIO_W-1:RATIO_W];
        end
        if (touch_now != last_decision)
            last_decision = touch_now;
        else if (touch_now != presence)
        begin
            presence = touch_now;
            presence_flips++;
        end
        r.present    = presence;
        r.active     = touch_now;
        r.calibrated = 1'b1;
        r.baseline   = base_est;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_raw(longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return RAW_MAX[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic push_poll(longint raw, bit ok);
        pad_poll_t p;
        p.raw = clamp_raw(raw);
        p.ok  = ok;
        polls_waiting.push_back(p);
        n_queued++;
    endtask

    // One stretch of pad activity around the current level
    task automatic queue_scene();
        int          kind;
        int          n;
        int          brk_at;
        bit          broken;
        int unsigned span;
        int unsigned rise;
        kind = $urandom_range(99);
        span = lvl / 8 + 1;
        if (kind < 30)
        begin
            n = $urandom_range(8, 3);
            repeat (n)
                push_poll(longint'(lvl) + $urandom_range(span / 2) - span / 4,
                          $urandom_range(99) >= 6);
        end
        else if (kind < 55)
        begin
            n = $urandom_range(8, 2);
            rise = ($urandom_range(3) == 0) ? $urandom_range(lvl * 2) :
                                              $urandom_range(lvl / 2 + 4);
            repeat (n)
                push_poll(longint'(lvl) + rise + $urandom_range(span / 4) - span / 8,
                          $urandom_range(99) >= 5);
            n = $urandom_range(4, 2);
            repeat (n)
                push_poll(lvl, 1'b1);
        end
        else if (kind < 80)
        begin
            // a full run of low readings moves the baseline down
            broken = $urandom_range(99) < 25;
            brk_at = $urandom_range(LOW_STREAK_DEF - 1);
            for (int i = 0; i < LOW_STREAK_DEF; i++)
            begin
                if (broken && i == brk_at)
                begin
                    case ($urandom_range(2))
                        0:       push_poll(lvl - 1, 1'b0);
                        1:       push_poll(0, 1'b1);
                        default: push_poll(longint'(lvl) + span, 1'b1);
                    endcase
                end
                else
                begin
                    push_poll(longint'(lvl) - 1 - $urandom_range(span - 1), 1'b1);
                end
            end
            if (!broken && lvl > 128)
                lvl = lvl - span / 2;
        end
        else
        begin
            n = $urandom_range(4, 1);
            repeat (n)
                push_poll($urandom_range(RAW_MAX), 1'($urandom_range(1)));
        end
    endtask

    task automatic write_ratios(logic [RATIO_W-1:0] ratio, logic [RATIO_W-1:0] hyst);
        cfg_valid <= 1'b1;
        cfg_index <= tpd_pkg::REG_ACTIVE_RATIO;
        cfg_data  <= ratio;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= tpd_pkg::REG_HYSTERESIS;
        cfg_data  <= hyst;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ratio_reg = ratio;
        hyst_reg  = hyst;
    endtask

    task automatic wait_drained();
        while (n_checked < n_queued)
            @(posedge clk);
    endtask

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results checked",
                     cycle_count, n_checked, n_queued);
            $display("FAIL");
            $finish;
        end
    end

    // Sample driver: predict on accept, hold the item until taken
    always @(posedge clk)
    begin : drive_samples
        pad_poll_t nxt;
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                results_due.push_back(poll_pad(raw_sample, read_ok));
                n_accepted++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (polls_waiting.size() > 0 &&
                    (no_gaps || $urandom_range(99) >= GAP_PERCENT))
                begin
                    nxt = polls_waiting.pop_front();
                    sample_valid <= 1'b1;
                    raw_sample   <= nxt.raw;
                    read_ok      <= nxt.ok;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver
    always @(posedge clk)
    begin : check_results
        pad_result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (results_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected result p=%0b a=%0b c=%0b base=%0d",
                               present, touch_active, calibrated, baseline_out));
                end
                else
                begin
                    want = results_due.pop_front();
                    n_checked++;
                    if (present !== want.present || touch_active !== want.active ||
                        calibrated !== want.calibrated || baseline_out !== want.baseline)
                        flag_error($sformatf(
                            {"result %0d exp p=%0b a=%0b c=%0b base=%0d ",
                             "got p=%0b a=%0b c=%0b base=%0d"},
                            n_checked, want.present, want.active, want.calibrated,
                            want.baseline, present, touch_active, calibrated, baseline_out));
                end
            end
            result_ready <= !hold_off && (no_gaps || $urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Long receiver hold-off so the input side backs up and stalls
    initial
    begin
        wait (n_accepted >= 200);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : run_phases
        int unsigned phase_lvl [RANDOM_PHASES];
        int          goal;
        phase_lvl = '{400000, 150000, 30000, 6000, 1200, 250, 80};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration: errors skipped, zero and full-scale readings counted
        push_poll(RAW_MAX, 1'b0);
        push_poll(0, 1'b1);
        push_poll(RAW_MAX, 1'b1);
        push_poll(12345, 1'b0);
        repeat (8) push_poll(1000, 1'b1);
        // baseline is now 420230, threshold 84044 at the reset ratio
        push_poll(520000, 1'b1);
        push_poll(520000, 1'b1);
        push_poll(495000, 1'b1);    // held by hysteresis
        push_poll(100, 1'b0);       // error keeps the last decision
        push_poll(420230, 1'b1);
        push_poll(420230, 1'b1);
        push_poll(0, 1'b1);         // zero reading never joins a low streak
        push_poll(504274, 1'b1);    // rise equal to threshold
        push_poll(504275, 1'b1);
        push_poll(504275, 1'b1);
        push_poll(504274, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: ;
                1: write_ratios(16'd0, 16'd0);
                2: write_ratios(16'hFFFF, 16'hFFFF);
                3: write_ratios(RATIO_W'($urandom_range(16'hFFFF)), 16'hFFFF);
                4: write_ratios(RATIO_W'($urandom_range(40000, 2000)),
                                RATIO_W'($urandom_range(8000)));
                5: write_ratios(RATIO_W'($urandom_range(16'hFFFF)),
                                RATIO_W'($urandom_range(16'hFFFF)));
                default: write_ratios(16'h8000, RATIO_W'($urandom_range(3000)));
            endcase
            no_gaps = (ph == 5);
            lvl = phase_lvl[ph];
            goal = n_queued + PHASE_ITEMS;
            while (n_queued < goal)
                queue_scene();
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (results_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", results_due.size()));
        $display("Checked %0d results from %0d readings over %0d ratio settings;",
                 n_checked, n_accepted, RANDOM_PHASES);
        $display("baseline moved by drift %0d times, presence changed %0d times, %0d mismatches.",
                 drift_updates, presence_flips, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
